// ----- rtl/cce_pkg.sv -----
`default_nettype none

package cce_pkg;

    localparam int BYTE_W      = 8;
    localparam int WIDTH_REG_W = 7;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int DIGEST_W    = 64;

    localparam logic [WIDTH_REG_W-1:0] RESET_WIDTH   = 7'd32;
    localparam logic [63:0]            RESET_POLY    = 64'h0000_0000_04C1_1DB7;
    localparam logic [63:0]            RESET_INIT    = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0]            RESET_XOR     = 64'h0000_0000_FFFF_FFFF;
    localparam logic [1:0]             RESET_REFLECT = 2'd3;

    localparam int REFLECT_BYTE_BIT = 0;
    localparam int REFLECT_OUT_BIT  = 1;

    localparam logic MODE_DATA   = 1'b0;
    localparam logic MODE_FINISH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRC_WIDTH     = 3'd0,
        CFG_POLYNOMIAL    = 3'd1,
        CFG_INITIAL_VALUE = 3'd2,
        CFG_FINAL_XOR     = 3'd3,
        CFG_REFLECT_MODE  = 3'd4
    } t_cfg_idx;

    function automatic logic [BYTE_W-1:0] reflect_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        for (int i = 0; i < BYTE_W; i++) begin
            r[i] = b[BYTE_W-1-i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/cce_absorb.sv -----
`default_nettype none

module cce_absorb
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic [MAX_WIDTH-1:0] i_rem,
    input  wire logic [MAX_WIDTH-1:0] i_poly,
    input  wire logic [BYTE_W-1:0]    i_byte,
    input  wire logic                 i_reflect,
    output logic      [MAX_WIDTH-1:0] o_rem
);

    logic [BYTE_W-1:0]    byte_in;
    logic [MAX_WIDTH-1:0] r;
    logic                 fb;

    always_comb begin
        byte_in = i_reflect ? reflect_byte(i_byte) : i_byte;
        r       = i_rem;
        for (int i = 0; i < BYTE_W; i++) begin
            fb = r[MAX_WIDTH-1] ^ byte_in[BYTE_W-1-i];
            r  = r << 1;
            if (fb) begin
                r = r ^ i_poly;
            end
        end
        o_rem = r;
    end

endmodule

`default_nettype wire

// ----- rtl/configurable_crc_engine.sv -----
`default_nettype none

// Configurable CRC engine, widths 1 to MAX_WIDTH bits. Polynomial, initial value, final XOR
// and the reflect options (bit 0: reflect each input byte, bit 1: reflect the result) are
// written through the configuration port; the user must write them only while the engine is
// idle, which the block does not enforce. Writing the initial value also reloads the running
// remainder. A data word (mode 0) absorbs one byte; a finish word (mode 1) emits the digest,
// masked to the width, and reloads the initial value. Every word is registered, then its whole
// byte is absorbed by an unrolled 8-step XOR network in the next cycle, so one word is taken
// per clock unless a finish word is held by a stalled output; the digest waits in the output
// register while stalled. Widths of 0 count as 1, widths above MAX_WIDTH count as MAX_WIDTH.

module configurable_crc_engine
    import cce_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_mode,
    input  wire logic [BYTE_W-1:0]     i_data_byte,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [DIGEST_W-1:0]   o_digest
);

    localparam int SH_W = $clog2(MAX_WIDTH + 1);

    function automatic logic [SH_W-1:0] f_shift(input logic [WIDTH_REG_W-1:0] w);
        logic [WIDTH_REG_W-1:0] e;
        if (w == '0) begin
            e = WIDTH_REG_W'(1);
        end else if (w > WIDTH_REG_W'(MAX_WIDTH)) begin
            e = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            e = w;
        end
        return SH_W'(WIDTH_REG_W'(MAX_WIDTH) - e);
    endfunction

    logic [WIDTH_REG_W-1:0] r_width;
    logic [MAX_WIDTH-1:0]   r_poly;
    logic [MAX_WIDTH-1:0]   r_init;
    logic [MAX_WIDTH-1:0]   r_xor;
    logic [1:0]             r_refl;
    logic [MAX_WIDTH-1:0]   r_rem;
    logic [MAX_WIDTH-1:0]   n_rem;

    logic                   r_in_valid;
    logic                   r_in_mode;
    logic [BYTE_W-1:0]      r_in_byte;
    logic                   r_out_valid;
    logic [DIGEST_W-1:0]    r_digest;
    logic [DIGEST_W-1:0]    n_digest;

    logic [SH_W-1:0]        sh;
    logic [MAX_WIDTH-1:0]   mask;
    logic [MAX_WIDTH-1:0]   poly_al;
    logic [MAX_WIDTH-1:0]   rem_al;
    logic [MAX_WIDTH-1:0]   absorbed;
    logic [MAX_WIDTH-1:0]   rem_rev;
    logic [MAX_WIDTH-1:0]   result;
    logic                   out_free;
    logic                   proc;
    logic                   in_accept;

    // absorb the byte with the CRC left-aligned in the top width bits
    assign sh      = f_shift(r_width);
    assign mask    = {MAX_WIDTH{1'b1}} >> sh;
    assign poly_al = r_poly << sh;
    assign rem_al  = r_rem << sh;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && ((r_in_mode == MODE_DATA) || out_free);
    assign o_in_stall = r_in_valid && !proc;
    assign in_accept  = i_in_valid && !o_in_stall;

    cce_absorb #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_absorb (
        .i_rem     (rem_al),
        .i_poly    (poly_al),
        .i_byte    (r_in_byte),
        .i_reflect (r_refl[REFLECT_BYTE_BIT]),
        .o_rem     (absorbed)
    );

    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            rem_rev[i] = rem_al[MAX_WIDTH-1-i];
        end
        result   = r_refl[REFLECT_OUT_BIT] ? rem_rev : r_rem;
        n_digest = DIGEST_W'((result ^ r_xor) & mask);
    end

    always_comb begin
        n_rem = r_rem;
        if (i_cfg_we && (i_cfg_index == CFG_INITIAL_VALUE)) begin
            n_rem = i_cfg_data[MAX_WIDTH-1:0] & mask;
        end else if (proc) begin
            n_rem = (r_in_mode == MODE_DATA) ? (absorbed >> sh) : (r_init & mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= RESET_WIDTH;
            r_poly      <= RESET_POLY[MAX_WIDTH-1:0];
            r_init      <= RESET_INIT[MAX_WIDTH-1:0];
            r_xor       <= RESET_XOR[MAX_WIDTH-1:0];
            r_refl      <= RESET_REFLECT;
            r_rem       <= RESET_INIT[MAX_WIDTH-1:0]
                           & ({MAX_WIDTH{1'b1}} >> f_shift(RESET_WIDTH));
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CRC_WIDTH:     r_width <= i_cfg_data[WIDTH_REG_W-1:0];
                    CFG_POLYNOMIAL:    r_poly  <= i_cfg_data[MAX_WIDTH-1:0];
                    CFG_INITIAL_VALUE: r_init  <= i_cfg_data[MAX_WIDTH-1:0];
                    CFG_FINAL_XOR:     r_xor   <= i_cfg_data[MAX_WIDTH-1:0];
                    CFG_REFLECT_MODE:  r_refl  <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            r_rem <= n_rem;
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc && (r_in_mode == MODE_FINISH)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_mode <= i_mode;
            r_in_byte <= i_data_byte;
        end
        if (proc && (r_in_mode == MODE_FINISH)) begin
            r_digest <= n_digest;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_digest    = r_digest;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_digest)))
        else $error("stalled digest dropped or changed");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && (r_in_mode == MODE_FINISH)))
        else $error("digest raised without a finish word");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && (r_in_mode == MODE_FINISH)))
        else $error("input stalled without a blocked digest");

    a_finish_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_in_mode == MODE_FINISH) && !i_cfg_we) |=> (r_rem == $past(r_init & mask)))
        else $error("remainder not reloaded after finish");

endmodule

`default_nettype wire

// ----- sim/crc_digest_checker.sv -----
module crc_digest_checker
    import cce_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic                  i_mode,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [DIGEST_W-1:0]   i_digest,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CRC_W = 64;

    logic [WIDTH_REG_W-1:0] width_reg;
    logic [63:0]            poly_reg;
    logic [63:0]            init_reg;
    logic [63:0]            xor_reg;
    logic [1:0]             reflect_reg;
    logic [63:0]            crc_state;
    logic [DIGEST_W-1:0]    expected_digests[$];
    int                     mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic int active_width(input logic [WIDTH_REG_W-1:0] w);
        if (w == '0) begin
            return 1;
        end
        if (int'(w) > MAX_CRC_W) begin
            return MAX_CRC_W;
        end
        return int'(w);
    endfunction

    function automatic logic [63:0] width_mask(input int w);
        if (w >= 64) begin
            return '1;
        end
        return (64'd1 << w) - 64'd1;
    endfunction

    function automatic logic [63:0] mirror(input logic [63:0] v, input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) begin
            r[n-1-i] = v[i];
        end
        return r;
    endfunction

    function automatic logic [63:0] absorb_byte(input logic [63:0] crc,
                                                input logic [BYTE_W-1:0] b,
                                                input int w,
                                                input logic [63:0] poly,
                                                input logic reflect_in);
        logic [63:0]       mask;
        logic [BYTE_W-1:0] msg;
        logic              top;
        mask = width_mask(w);
        crc  = crc & mask;
        poly = poly & mask;
        for (int i = 0; i < BYTE_W; i++) begin
            msg[i] = reflect_in ? b[BYTE_W-1-i] : b[i];
        end
        for (int i = 0; i < BYTE_W; i++) begin
            top = crc[w-1];
            crc = (crc << 1) & mask;
            if (top ^ msg[BYTE_W-1-i]) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

    function automatic logic [63:0] finish_digest(input logic [63:0] crc, input int w,
                                                  input logic [63:0] xor_val,
                                                  input logic reflect_out);
        logic [63:0] mask;
        mask = width_mask(w);
        crc  = crc & mask;
        if (reflect_out) begin
            crc = mirror(crc, w);
        end
        return (crc ^ xor_val) & mask;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge i_clk) begin
        int                  w;
        logic [DIGEST_W-1:0] want;
        if (!i_rst_n) begin
            width_reg   = RESET_WIDTH;
            poly_reg    = RESET_POLY;
            init_reg    = RESET_INIT;
            xor_reg     = RESET_XOR;
            reflect_reg = RESET_REFLECT;
            crc_state   = RESET_INIT & width_mask(active_width(RESET_WIDTH));
            expected_digests.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_digests.size() == 0) begin
                    log_mismatch($sformatf("unexpected digest %h", i_digest));
                end else begin
                    want = expected_digests.pop_front();
                    if (i_digest !== want) begin
                        log_mismatch($sformatf("digest mismatch: expected %h, got %h",
                                               want, i_digest));
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CRC_WIDTH:     width_reg = i_cfg_data[WIDTH_REG_W-1:0];
                    CFG_POLYNOMIAL:    poly_reg = i_cfg_data;
                    CFG_INITIAL_VALUE: begin
                        init_reg  = i_cfg_data;
                        crc_state = i_cfg_data & width_mask(active_width(width_reg));
                    end
                    CFG_FINAL_XOR:     xor_reg = i_cfg_data;
                    CFG_REFLECT_MODE:  reflect_reg = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                w = active_width(width_reg);
                if (i_mode == MODE_DATA) begin
                    crc_state = absorb_byte(crc_state, i_data_byte, w, poly_reg,
                                            reflect_reg[REFLECT_BYTE_BIT]);
                end else begin
                    expected_digests.push_back(finish_digest(crc_state, w, xor_reg,
                                                             reflect_reg[REFLECT_OUT_BIT]));
                    crc_state = init_reg & width_mask(w);
                end
            end
        end
        o_outstanding <= expected_digests.size();
    end

endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cce_pkg::*;

    localparam int CFG_COUNT  = 5;
    localparam int WORD_QUOTA = 2000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic                  mode        = MODE_DATA;
    logic [BYTE_W-1:0]     data_byte   = '0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic [DIGEST_W-1:0]   digest;
    int                    fail_count;
    int                    outstanding;
    int                    words_sent  = 0;
    bit                    steady_input = 1'b0;

    configurable_crc_engine dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_mode      (mode),
        .i_data_byte (data_byte),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_digest    (digest)
    );

    crc_digest_checker digest_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_mode        (mode),
        .i_data_byte   (data_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_digest      (digest),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #8_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WIDTH_REG_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'($urandom_range(65, 127));
            4:       return 7'd8;
            5:       return 7'd32;
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return rand64() & ~64'd1;
            3:       return {56'd0, 8'($urandom)};
            default: return rand64();
        endcase
    endfunction

    // hold stall in runs: mostly short, a few long, with quiet stretches between
    initial begin
        int quiet;
        int hold;
        @(posedge clk);
        forever begin
            quiet = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 4);
            hold  = pick_gap();
            out_stall <= 1'b0;
            repeat (quiet) @(posedge clk);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic m, input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady_input ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid  <= 1'b0;
            mode      <= 1'($urandom);
            data_byte <= 8'($urandom);
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_registers(input logic [63:0] vals [CFG_COUNT],
                                  input logic [CFG_COUNT-1:0] pick, input bit stray);
        settle();
        if (pick[CFG_CRC_WIDTH])     write_reg(CFG_CRC_WIDTH, vals[CFG_CRC_WIDTH]);
        if (pick[CFG_POLYNOMIAL])    write_reg(CFG_POLYNOMIAL, vals[CFG_POLYNOMIAL]);
        if (pick[CFG_INITIAL_VALUE]) write_reg(CFG_INITIAL_VALUE, vals[CFG_INITIAL_VALUE]);
        if (pick[CFG_FINAL_XOR])     write_reg(CFG_FINAL_XOR, vals[CFG_FINAL_XOR]);
        if (pick[CFG_REFLECT_MODE])  write_reg(CFG_REFLECT_MODE, vals[CFG_REFLECT_MODE]);
        if (stray) begin
            write_reg(CFG_IDX_W'(CFG_REFLECT_MODE + $urandom_range(1, 3)), rand64());
        end
        cfg_we <= 1'b0;
    endtask

    // leave a partial message behind now and then so its remainder crosses the reconfiguration
    task automatic run_traffic();
        int len;
        steady_input = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(2, 10)) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
            repeat (len) send_word(MODE_DATA, 8'($urandom));
            send_word(MODE_FINISH, 8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 6)) send_word(MODE_DATA, 8'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [63:0]          vals [CFG_COUNT];
        logic [CFG_COUNT-1:0] pick;
        bit                   stray;
        int                   phase;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(MODE_FINISH, 8'h00);
        send_word(MODE_DATA, 8'h00);
        send_word(MODE_DATA, 8'hFF);
        send_word(MODE_FINISH, 8'h00);
        send_word(MODE_DATA, 8'h01);
        send_word(MODE_DATA, 8'h80);
        send_word(MODE_DATA, 8'hA5);
        send_word(MODE_DATA, 8'h5A);
        send_word(MODE_FINISH, 8'hFF);
        send_word(MODE_FINISH, 8'h00);
        for (int i = 0; i < 9; i++) begin
            send_word(MODE_DATA, 8'h31 + 8'(i));
        end
        send_word(MODE_FINISH, 8'h00);

        phase = 0;
        while (words_sent < WORD_QUOTA) begin
            case (phase)
                0: begin
                    vals[CFG_CRC_WIDTH]     = 64'd0;
                    vals[CFG_POLYNOMIAL]    = '1;
                    vals[CFG_INITIAL_VALUE] = '0;
                    vals[CFG_FINAL_XOR]     = '0;
                    vals[CFG_REFLECT_MODE]  = 64'd0;
                end
                1: begin
                    vals[CFG_CRC_WIDTH]     = 64'd127;
                    vals[CFG_POLYNOMIAL]    = 64'h42F0_E1EB_A9EA_3693;
                    vals[CFG_INITIAL_VALUE] = '1;
                    vals[CFG_FINAL_XOR]     = '1;
                    vals[CFG_REFLECT_MODE]  = 64'd3;
                end
                2: begin
                    vals[CFG_CRC_WIDTH]     = 64'd64;
                    vals[CFG_POLYNOMIAL]    = rand64() & ~64'd1;
                    vals[CFG_INITIAL_VALUE] = rand64();
                    vals[CFG_FINAL_XOR]     = rand64();
                    vals[CFG_REFLECT_MODE]  = 64'd1;
                end
                3: begin
                    vals[CFG_CRC_WIDTH]           = rand64();
                    vals[CFG_CRC_WIDTH][6:0]      = 7'd8;
                    vals[CFG_POLYNOMIAL]          = rand64();
                    vals[CFG_POLYNOMIAL][7:0]     = 8'h07;
                    vals[CFG_INITIAL_VALUE]       = rand64();
                    vals[CFG_FINAL_XOR]           = rand64();
                    vals[CFG_REFLECT_MODE]        = rand64();
                    vals[CFG_REFLECT_MODE][1:0]   = 2'd2;
                end
                default: begin
                    vals[CFG_CRC_WIDTH]         = rand64();
                    vals[CFG_CRC_WIDTH][6:0]    = pick_width();
                    vals[CFG_POLYNOMIAL]        = pick_value();
                    vals[CFG_INITIAL_VALUE]     = pick_value();
                    vals[CFG_FINAL_XOR]         = pick_value();
                    vals[CFG_REFLECT_MODE]      = rand64();
                end
            endcase
            pick  = (phase < 4) ? '1 : CFG_COUNT'($urandom);
            stray = (phase == 3) || ($urandom_range(0, 4) == 0);
            load_registers(vals, pick, stray);
            run_traffic();
            phase++;
        end

        settle();
        if (fail_count == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
